/* hw/rtl/hmls_pkg.sv */
// Package for the health monitor / LED sequencer: item structs, op codes,
// configuration register indexes and constants.
// Depends on nothing; used by health_monitor_led_sequencer.
`default_nettype none

package hmls_pkg;

    // Widths of the item fields
    localparam int unsigned OP_W      = 3;
    localparam int unsigned PAT_W     = 32;
    localparam int unsigned POS_W     = 5;
    localparam int unsigned VOLT_W    = 16;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_W     = 32;

    // Voltage minimum starts at full scale so the first sample replaces it
    localparam logic [VOLT_W-1:0] VOLT_FULL = 16'hFFFF;
    // Last bit position of the blink pattern
    localparam logic [POS_W-1:0] POS_LAST = 5'd31;

    // Op codes carried in the op field
    typedef enum logic [OP_W-1:0] {
        OP_TICK        = 3'd0,
        OP_SET_PATTERN = 3'd1,
        OP_RAISE_ERROR = 3'd2,
        OP_CLEAR_ERROR = 3'd3,
        OP_SET_ENABLE  = 3'd4
    } op_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OK_PATTERN       = 2'd0,
        CFG_ERROR_PATTERN    = 2'd1,
        CFG_OVERLOAD_PATTERN = 2'd2,
        CFG_OVERCURRENT_BIT  = 2'd3
    } cfg_index_t;

    // Input item
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic              overcurrent;
        logic [VOLT_W-1:0] voltage_sample;
        logic              card_switch;
        logic              mount_ok;
        logic [PAT_W-1:0]  pattern_value;
        logic [POS_W-1:0]  error_index;
        logic              enable;
    } in_item_t;

    // Result item
    typedef struct packed {
        logic              led_one;
        logic              led_two;
        logic [VOLT_W-1:0] voltage_now;
        logic [VOLT_W-1:0] voltage_low;
        logic [VOLT_W-1:0] voltage_high;
        logic [PAT_W-1:0]  error_bits;
        logic              card_ejected;
        logic              card_inserted;
    } out_item_t;

endpackage

`default_nettype wire

/* hw/rtl/health_monitor_led_sequencer.sv */
// Health monitor and LED sequencer top level; depends on hmls_pkg.
// The result of an accepted item is registered, in the output register or else in the skid entry.
// Throughput: one item per cycle, the update being one pass of compares and bit
// selects into the result register; a skid entry holds one result during a stall, and
// with both entries full the input stalls until the skid entry drains.
// Reset (rst_n low, async): blinker on, voltage min at full scale, payload kept, rest 0.
`default_nettype none

module health_monitor_led_sequencer (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // Item input channel
    input  wire logic                               in_valid,
    output      logic                               in_stall,
    input  wire hmls_pkg::in_item_t                 in_item,
    // Result channel
    output      logic                               out_valid,
    input  wire logic                               out_stall,
    output      hmls_pkg::out_item_t                out_item,
    // Configuration write port
    input  wire logic                               cfg_write,
    input  wire logic [hmls_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [hmls_pkg::CFG_W-1:0]         cfg_data
);
    import hmls_pkg::*;

    // Configuration registers
    logic [PAT_W-1:0] ok_pattern_reg;
    logic [PAT_W-1:0] error_pattern_reg;
    logic [PAT_W-1:0] overload_pattern_reg;
    logic [POS_W-1:0] oc_bit_reg;

    // Monitor state
    logic [PAT_W-1:0]  blink_pattern_reg, blink_pattern_next;
    logic [POS_W-1:0]  bit_position_reg,  bit_position_next;
    logic              repeat_reg,        repeat_next;
    logic              blinker_on_reg,    blinker_on_next;
    logic [1:0]        led_reg,           led_next;
    logic [VOLT_W-1:0] volt_last_reg,     volt_last_next;
    logic [VOLT_W-1:0] volt_min_reg,      volt_min_next;
    logic [VOLT_W-1:0] volt_max_reg,      volt_max_next;
    logic [PAT_W-1:0]  error_flags_reg,   error_flags_next;
    logic              switch_prev_reg,   switch_prev_next;
    logic              ejected_next;
    logic              inserted_next;

    // Result buffer
    logic      out_valid_reg;
    logic      skid_valid_reg;
    out_item_t out_item_reg;
    out_item_t skid_item_reg;
    out_item_t result;

    logic in_accept;
    logic out_take;

    // Tick scratch values
    logic [PAT_W-1:0] pat_oc;
    logic             rep_oc;
    logic [POS_W-1:0] pos_oc;
    logic [POS_W-1:0] pos_plus1;
    logic [POS_W:0]   pos_plus2;

    assign in_accept = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;
    assign in_stall  = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ok_pattern_reg       <= '0;
            error_pattern_reg    <= '0;
            overload_pattern_reg <= '0;
            oc_bit_reg           <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_OK_PATTERN:       ok_pattern_reg       <= cfg_data;
                CFG_ERROR_PATTERN:    error_pattern_reg    <= cfg_data;
                CFG_OVERLOAD_PATTERN: overload_pattern_reg <= cfg_data;
                CFG_OVERCURRENT_BIT:  oc_bit_reg           <= cfg_data[POS_W-1:0];
                default:              ;
            endcase
        end
    end

    // Next state for one item
    always_comb
    begin
        blink_pattern_next = blink_pattern_reg;
        bit_position_next  = bit_position_reg;
        repeat_next        = repeat_reg;
        blinker_on_next    = blinker_on_reg;
        led_next           = led_reg;
        volt_last_next     = volt_last_reg;
        volt_min_next      = volt_min_reg;
        volt_max_next      = volt_max_reg;
        error_flags_next   = error_flags_reg;
        switch_prev_next   = switch_prev_reg;
        ejected_next       = 1'b0;
        inserted_next      = 1'b0;

        // Overcurrent loads the overload pattern, no repeat, position zero
        pat_oc = in_item.overcurrent ? overload_pattern_reg : blink_pattern_reg;
        rep_oc = in_item.overcurrent ? 1'b0 : repeat_reg;
        pos_oc = in_item.overcurrent ? '0 : bit_position_reg;

        // LEDs use the position held at the start of the tick
        pos_plus1 = bit_position_reg + POS_W'(1);
        pos_plus2 = {1'b0, bit_position_reg} + (POS_W+1)'(2);

        case (in_item.op)
            OP_TICK:
            begin
                if (in_item.overcurrent)
                begin
                    error_flags_next = error_flags_reg | (PAT_W'(1) << oc_bit_reg);
                end
                blink_pattern_next = pat_oc;
                repeat_next        = rep_oc;
                bit_position_next  = pos_oc;

                if (blinker_on_reg)
                begin
                    led_next = {pat_oc[pos_plus1], pat_oc[bit_position_reg]};
                    // Wrap past the last bit: back to zero, OK pattern unless repeating
                    if (pos_plus2 > {1'b0, POS_LAST})
                    begin
                        bit_position_next = '0;
                        if (!rep_oc)
                        begin
                            blink_pattern_next = ok_pattern_reg;
                        end
                    end
                    else
                    begin
                        bit_position_next = pos_plus2[POS_W-1:0];
                    end
                end

                // Voltage tracking
                volt_last_next = in_item.voltage_sample;
                if (in_item.voltage_sample > volt_max_reg)
                begin
                    volt_max_next = in_item.voltage_sample;
                end
                if (in_item.voltage_sample < volt_min_reg)
                begin
                    volt_min_next = in_item.voltage_sample;
                end

                // Card switch edges; a failed mount on insert shows overload
                if (in_item.card_switch && !switch_prev_reg)
                begin
                    ejected_next = 1'b1;
                end
                else if (!in_item.card_switch && switch_prev_reg)
                begin
                    inserted_next = 1'b1;
                    if (!in_item.mount_ok)
                    begin
                        bit_position_next  = '0;
                        blink_pattern_next = overload_pattern_reg;
                    end
                end
                switch_prev_next = in_item.card_switch;
            end
            OP_SET_PATTERN:
            begin
                blink_pattern_next = in_item.pattern_value;
                bit_position_next  = '0;
            end
            OP_RAISE_ERROR:
            begin
                error_flags_next   = error_flags_reg | (PAT_W'(1) << in_item.error_index);
                repeat_next        = 1'b1;
                blink_pattern_next = error_pattern_reg;
                bit_position_next  = '0;
            end
            OP_CLEAR_ERROR:
            begin
                error_flags_next = '0;
            end
            OP_SET_ENABLE:
            begin
                blinker_on_next = in_item.enable;
            end
            default:
            begin
            end
        endcase
    end

    // Result from the state after this item
    always_comb
    begin
        result.led_one       = led_next[0];
        result.led_two       = led_next[1];
        result.voltage_now   = volt_last_next;
        result.voltage_low   = volt_min_next;
        result.voltage_high  = volt_max_next;
        result.error_bits    = error_flags_next;
        result.card_ejected  = ejected_next;
        result.card_inserted = inserted_next;
    end

    // State registers, updated on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blink_pattern_reg <= '0;
            bit_position_reg  <= '0;
            repeat_reg        <= 1'b0;
            blinker_on_reg    <= 1'b1;
            led_reg           <= '0;
            volt_last_reg     <= '0;
            volt_min_reg      <= VOLT_FULL;
            volt_max_reg      <= '0;
            error_flags_reg   <= '0;
            switch_prev_reg   <= 1'b0;
        end
        else if (in_accept)
        begin
            blink_pattern_reg <= blink_pattern_next;
            bit_position_reg  <= bit_position_next;
            repeat_reg        <= repeat_next;
            blinker_on_reg    <= blinker_on_next;
            led_reg           <= led_next;
            volt_last_reg     <= volt_last_next;
            volt_min_reg      <= volt_min_next;
            volt_max_reg      <= volt_max_next;
            error_flags_reg   <= error_flags_next;
            switch_prev_reg   <= switch_prev_next;
        end
    end

    // Result buffer control: skid drains first, new item fills the free slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (in_accept)
        begin
            if (out_valid_reg && !out_take)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result buffer payload
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_item_reg <= skid_item_reg;
            end
        end
        else if (in_accept)
        begin
            if (out_valid_reg && !out_take)
            begin
                skid_item_reg <= result;
            end
            else
            begin
                out_item_reg <= result;
            end
        end
    end

endmodule

`default_nettype wire

/* tb/tb_health_monitor_led_sequencer.sv */
// Self-checking testbench for health_monitor_led_sequencer: directed and random items,
// with a scoreboard class that predicts LED, voltage, error and card results per item.
// Depends on hmls_pkg and the health_monitor_led_sequencer RTL.
module tb_health_monitor_led_sequencer;
    import hmls_pkg::*;

    localparam int          IDLE_PCT       = 13;
    localparam int          HOLD_CYCLES    = 120;
    localparam int          QUIET_LIMIT    = 1000;
    localparam int          DRAIN_MARGIN   = 4;
    localparam int          PHASES         = 6;
    localparam int          PHASE_ITEMS    = 150;
    localparam int          ZERO_PHASE     = 0;
    localparam int          CALM_PHASE     = 1;
    localparam int          FULL_PHASE     = 2;
    localparam int          PRESSURE_PHASE = 3;
    // Op codes the block does not define; such items change nothing
    localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

    // Predicts the status result of each item and holds results still to come
    class status_scoreboard;
        logic [PAT_W-1:0]  ok_pat   = '0;
        logic [PAT_W-1:0]  err_pat  = '0;
        logic [PAT_W-1:0]  ovl_pat  = '0;
        logic [POS_W-1:0]  oc_bit   = '0;

        logic [PAT_W-1:0]  pattern   = '0;
        logic [POS_W-1:0]  pos       = '0;
        bit                repeat_on = 1'b0;
        bit                blink_on  = 1'b1;
        logic [1:0]        leds      = '0;
        logic [VOLT_W-1:0] v_last    = '0;
        logic [VOLT_W-1:0] v_min     = VOLT_FULL;
        logic [VOLT_W-1:0] v_max     = '0;
        logic [PAT_W-1:0]  flags     = '0;
        bit                sw_prev   = 1'b0;

        out_item_t expected_status_q[$];
        int unsigned fail_count = 0;

        function int pending();
            return expected_status_q.size();
        endfunction

        function void set_reg(cfg_index_t idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_OK_PATTERN:       ok_pat  = data;
                CFG_ERROR_PATTERN:    err_pat = data;
                CFG_OVERLOAD_PATTERN: ovl_pat = data;
                CFG_OVERCURRENT_BIT:  oc_bit  = data[POS_W-1:0];
                default: ;
            endcase
        endfunction

        // Advance the monitor state by one accepted item and queue its result
        function void note_item(in_item_t it);
            logic [POS_W-1:0] start;
            bit               ejected;
            bit               inserted;
            out_item_t        r;
            ejected  = 1'b0;
            inserted = 1'b0;
            case (it.op)
                OP_TICK:
                begin
                    start = pos;
                    // overcurrent: flag, overload pattern, no repeat
                    if (it.overcurrent)
                    begin
                        flags[oc_bit] = 1'b1;
                        pattern       = ovl_pat;
                        repeat_on     = 1'b0;
                        pos           = '0;
                    end
                    // LEDs use the position held at the start of the tick
                    if (blink_on)
                    begin
                        leds = {pattern[start + 5'd1], pattern[start]};
                        if ({1'b0, start} + 6'd2 > {1'b0, POS_LAST})
                        begin
                            if (!repeat_on)
                                pattern = ok_pat;
                            pos = '0;
                        end
                        else
                            pos = start + 5'd2;
                    end
                    if (it.voltage_sample > v_max)
                        v_max = it.voltage_sample;
                    if (it.voltage_sample < v_min)
                        v_min = it.voltage_sample;
                    v_last = it.voltage_sample;
                    // card switch edges; a failed mount loads the overload pattern
                    if (it.card_switch && !sw_prev)
                        ejected = 1'b1;
                    else if (!it.card_switch && sw_prev)
                    begin
                        inserted = 1'b1;
                        if (!it.mount_ok)
                        begin
                            pos     = '0;
                            pattern = ovl_pat;
                        end
                    end
                    sw_prev = it.card_switch;
                end
                OP_SET_PATTERN:
                begin
                    pattern = it.pattern_value;
                    pos     = '0;
                end
                OP_RAISE_ERROR:
                begin
                    flags[it.error_index] = 1'b1;
                    repeat_on = 1'b1;
                    pattern   = err_pat;
                    pos       = '0;
                end
                OP_CLEAR_ERROR: flags = '0;
                OP_SET_ENABLE:  blink_on = it.enable;
                default: ;
            endcase
            r.led_one       = leds[0];
            r.led_two       = leds[1];
            r.voltage_now   = v_last;
            r.voltage_low   = v_min;
            r.voltage_high  = v_max;
            r.error_bits    = flags;
            r.card_ejected  = ejected;
            r.card_inserted = inserted;
            expected_status_q.push_back(r);
        endfunction

        task report(string msg);
            fail_count++;
            $display("mismatch %0d at %0t: %s", fail_count, $time, msg);
        endtask

        // Compare one accepted result with the oldest expected one
        task check_result(out_item_t got);
            out_item_t exp;
            if (expected_status_q.size() == 0)
            begin
                report("result with no item waiting for it");
                return;
            end
            exp = expected_status_q.pop_front();
            if (got.led_one !== exp.led_one)
                report($sformatf("led_one got %0h exp %0h", got.led_one, exp.led_one));
            if (got.led_two !== exp.led_two)
                report($sformatf("led_two got %0h exp %0h", got.led_two, exp.led_two));
            if (got.voltage_now !== exp.voltage_now)
                report($sformatf("voltage_now got %0h exp %0h",
                                 got.voltage_now, exp.voltage_now));
            if (got.voltage_low !== exp.voltage_low)
                report($sformatf("voltage_low got %0h exp %0h",
                                 got.voltage_low, exp.voltage_low));
            if (got.voltage_high !== exp.voltage_high)
                report($sformatf("voltage_high got %0h exp %0h",
                                 got.voltage_high, exp.voltage_high));
            if (got.error_bits !== exp.error_bits)
                report($sformatf("error_bits got %0h exp %0h",
                                 got.error_bits, exp.error_bits));
            if (got.card_ejected !== exp.card_ejected)
                report($sformatf("card_ejected got %0h exp %0h",
                                 got.card_ejected, exp.card_ejected));
            if (got.card_inserted !== exp.card_inserted)
                report($sformatf("card_inserted got %0h exp %0h",
                                 got.card_inserted, exp.card_inserted));
        endtask
    endclass

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    in_item_t             in_item   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    out_item_t            out_item;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    status_scoreboard sb = new();
    bit               calm     = 1'b0;
    bit               hold_req = 1'b0;
    int               hold_left = 0;
    int               quiet_cycles = 0;
    bit               sw_level = 1'b0;

    wire in_take  = in_valid && !in_stall;
    wire out_take = out_valid && !out_stall;

    health_monitor_led_sequencer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    // Sample both channels at the rising edge; watchdog on cycles with no traffic
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_take)
                sb.note_item(in_item);
            if (out_take)
                sb.check_result(out_item);
            if (in_take || out_take || cfg_write)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Result receiver: random stalls, a long hold-off on request
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // Random bits for every field of an item
    function automatic in_item_t rand_item();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[$bits(in_item_t)-1:0];
    endfunction

    // Offer one item and hold it until accepted; entered and left at a falling edge
    task send_item(in_item_t it);
        if (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(2, 1)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task send_tick(bit oc, logic [VOLT_W-1:0] v, bit sw, bit mnt);
        in_item_t it;
        it = rand_item();
        it.op             = OP_TICK;
        it.overcurrent    = oc;
        it.voltage_sample = v;
        it.card_switch    = sw;
        it.mount_ok       = mnt;
        send_item(it);
    endtask

    // Non-tick op; the argument feeds pattern, error index and enable alike
    task send_cmd(logic [OP_W-1:0] code, logic [PAT_W-1:0] arg);
        in_item_t it;
        it = rand_item();
        it.op            = code;
        it.pattern_value = arg;
        it.error_index   = arg[POS_W-1:0];
        it.enable        = arg[0];
        send_item(it);
    endtask

    // Stop offering and wait until every expected result has come back
    task drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    // Write all four registers while the block is idle
    task configure(logic [PAT_W-1:0] ok_p, logic [PAT_W-1:0] err_p,
                   logic [PAT_W-1:0] ovl_p, logic [POS_W-1:0] oc_b);
        cfg_index_t       idx;
        logic [CFG_W-1:0] vals [4];
        vals[CFG_OK_PATTERN]       = ok_p;
        vals[CFG_ERROR_PATTERN]    = err_p;
        vals[CFG_OVERLOAD_PATTERN] = ovl_p;
        vals[CFG_OVERCURRENT_BIT]  = CFG_W'(oc_b);
        idx = idx.first();
        repeat (idx.num())
        begin
            cfg_write <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= vals[idx];
            sb.set_reg(idx, vals[idx]);
            @(negedge clk);
            idx = idx.next();
        end
        cfg_write <= 1'b0;
    endtask

    // Random item: mostly ticks so patterns run through to the wrap
    task send_random();
        in_item_t it;
        int       roll;
        it   = rand_item();
        roll = $urandom_range(99);
        if (roll < 66)
            it.op = OP_TICK;
        else if (roll < 74)
            it.op = OP_SET_PATTERN;
        else if (roll < 80)
            it.op = OP_RAISE_ERROR;
        else if (roll < 85)
            it.op = OP_CLEAR_ERROR;
        else if (roll < 94)
            it.op = OP_SET_ENABLE;
        else
            it.op = OP_W'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
        it.overcurrent = ($urandom_range(24) == 0);
        if ($urandom_range(9) == 0)
            sw_level = ~sw_level;
        it.card_switch = sw_level;
        it.mount_ok    = ($urandom_range(3) != 0);
        it.enable      = ($urandom_range(3) != 0);
        send_item(it);
    endtask

    // Main sequence
    initial
    begin
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part
        configure(32'hF0F0_0F0F, 32'h5555_AAAA, 32'h9999_6666, POS_LAST);
        send_cmd(OP_UNUSED_HI, '1);
        send_tick(1'b0, 16'h0000, 1'b1, 1'b1);
        send_tick(1'b0, VOLT_FULL, 1'b0, 1'b0);
        send_tick(1'b1, 16'h8000, 1'b0, 1'b1);
        send_cmd(OP_RAISE_ERROR, 32'd0);
        send_cmd(OP_RAISE_ERROR, 32'd31);
        send_cmd(OP_CLEAR_ERROR, '1);
        send_cmd(OP_SET_ENABLE, '0);
        send_tick(1'b1, 16'h1234, 1'b1, 1'b1);
        send_cmd(OP_SET_ENABLE, '1);
        send_cmd(OP_SET_PATTERN, 32'hC3A5_5A3C);
        for (int k = 0; k < 15; k++)
            send_tick(1'b0, 16'($urandom), k[2], 1'b1);
        // wrap and overcurrent on one tick
        send_tick(1'b1, 16'($urandom), 1'b0, 1'b1);
        drain();

        // Random phases, each under its own register setting
        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase == ZERO_PHASE)
                configure('0, '0, '0, '0);
            else if (phase == FULL_PHASE)
                configure('1, '1, '1, POS_LAST);
            else
                configure($urandom, $urandom, $urandom, POS_W'($urandom));
            calm = (phase == CALM_PHASE);
            if (phase == PRESSURE_PHASE)
                hold_req = 1'b1;
            repeat (PHASE_ITEMS) send_random();
            drain();
        end
        calm = 1'b0;

        repeat (DRAIN_MARGIN) @(negedge clk);
        if (sb.fail_count == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
